### rtl/usan_pkg.sv
// Shared types and constants for the UTF-8 stream sanitizer.
package usan_pkg;

    // Replacement character written for every rejected byte.
    localparam logic [7:0] REPL_BYTE = 8'h3F;

    // Most output bytes that one input byte can cause.
    localparam int MAX_RUN = 4;

    // Default number of runs the queue between front and back can hold.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // One run: the output bytes caused by one input byte.
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [2:0]              count;
        logic                    done;
    } run_t;

    // Head of the queue as seen by the back part.
    typedef struct packed {
        logic valid;
        run_t run;
    } head_t;

endpackage

### rtl/usan_front.sv
// Front part: accepts bytes, tracks the pending sequence and builds output runs.
module usan_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       in_byte,
    input  logic             final_byte,
    input  logic             queue_full,
    output logic             run_write,
    output usan_pkg::run_t   run_data
);

    logic [7:0]      lead_reg;
    logic [7:0]      lead_next;
    logic [1:0]      needed_reg;
    logic [1:0]      needed_next;
    logic [1:0]      held_cnt_reg;
    logic [1:0]      held_cnt_next;
    logic [1:0][7:0] held_reg;

    logic            accept;
    logic            pending;
    logic            is_cont;
    logic            complete;
    logic            cut_off;
    logic            hold_cont;
    logic            fresh_hold;
    logic            fresh_emit;
    logic [7:0]      fresh_byte;
    logic [7:0]      tail_byte;
    logic [1:0]      lead_need;
    usan_pkg::run_t  run;

    assign accept   = in_valid && !in_stall;
    assign in_stall = queue_full;

    assign pending  = (needed_reg != 2'd0);
    assign is_cont  = (in_byte[7:6] == 2'b10);
    assign complete = pending && is_cont && (({1'b0, held_cnt_reg} + 3'd1) >= {1'b0, needed_reg});
    assign cut_off  = pending && is_cont && !complete && final_byte;
    assign hold_cont = pending && is_cont && !complete && !final_byte;

    // Classify the byte as if no sequence were pending.
    always_comb
    begin
        fresh_hold = 1'b0;
        fresh_byte = usan_pkg::REPL_BYTE;
        if (!in_byte[7])
        begin
            if (in_byte >= 8'h20 || in_byte == 8'h09 || in_byte == 8'h0A)
            begin
                fresh_byte = in_byte;
            end
        end
        else if (in_byte >= 8'hC0 && in_byte < 8'hF8)
        begin
            fresh_hold = !final_byte;
        end
    end

    assign fresh_emit = !fresh_hold;

    // Number of continuations a lead byte asks for.
    always_comb
    begin
        if (in_byte < 8'hE0)
        begin
            lead_need = 2'd1;
        end
        else if (in_byte < 8'hF0)
        begin
            lead_need = 2'd2;
        end
        else
        begin
            lead_need = 2'd3;
        end
    end

    // The byte that follows the flushed or completed prefix.
    always_comb
    begin
        if (complete)
        begin
            tail_byte = in_byte;
        end
        else if (cut_off)
        begin
            tail_byte = usan_pkg::REPL_BYTE;
        end
        else
        begin
            tail_byte = fresh_byte;
        end
    end

    // Assemble the run: lead, held continuations, then the tail byte.
    always_comb
    begin
        run.done = final_byte;
        if (pending)
        begin
            run.bytes[0] = complete ? lead_reg : usan_pkg::REPL_BYTE;
            run.bytes[1] = (held_cnt_reg >= 2'd1) ?
                           (complete ? held_reg[0] : usan_pkg::REPL_BYTE) : tail_byte;
            run.bytes[2] = (held_cnt_reg >= 2'd2) ?
                           (complete ? held_reg[1] : usan_pkg::REPL_BYTE) : tail_byte;
            run.bytes[3] = tail_byte;
            if (hold_cont)
            begin
                run.count = 3'd0;
            end
            else if (complete || cut_off)
            begin
                run.count = {1'b0, held_cnt_reg} + 3'd2;
            end
            else
            begin
                run.count = {1'b0, held_cnt_reg} + 3'd1 + {2'b00, fresh_emit};
            end
        end
        else
        begin
            run.bytes[0] = fresh_byte;
            run.bytes[1] = fresh_byte;
            run.bytes[2] = fresh_byte;
            run.bytes[3] = fresh_byte;
            run.count    = {2'b00, fresh_emit};
        end
    end

    assign run_write = accept && (run.count != 3'd0);
    assign run_data  = run;

    // Next pending-sequence state.
    always_comb
    begin
        lead_next     = lead_reg;
        needed_next   = needed_reg;
        held_cnt_next = held_cnt_reg;
        if (hold_cont)
        begin
            held_cnt_next = held_cnt_reg + 2'd1;
        end
        else if (!complete && !cut_off && fresh_hold)
        begin
            lead_next     = in_byte;
            needed_next   = lead_need;
            held_cnt_next = 2'd0;
        end
        else
        begin
            lead_next     = 8'h00;
            needed_next   = 2'd0;
            held_cnt_next = 2'd0;
        end
    end

    // Control state of the pending sequence.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg     <= 8'h00;
            needed_reg   <= 2'd0;
            held_cnt_reg <= 2'd0;
        end
        else if (accept)
        begin
            lead_reg     <= lead_next;
            needed_reg   <= needed_next;
            held_cnt_reg <= held_cnt_next;
        end
    end

    // Held continuation bytes; read only after being written.
    always_ff @(posedge clk)
    begin
        if (accept && hold_cont)
        begin
            held_reg[held_cnt_reg[0]] <= in_byte;
        end
    end

endmodule

### rtl/usan_queue.sv
// Run queue between the front and back parts.
module usan_queue
#(
    parameter int DEPTH = usan_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  usan_pkg::run_t  wr_data,
    output logic            full,
    input  logic            rd_en,
    output usan_pkg::head_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    usan_pkg::run_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.run   = entry_reg[rd_ptr_reg];
    assign do_wr      = wr_en && !full;
    assign do_rd      = rd_en && head.valid;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/usan_back.sv
// Back part: walks each queued run and presents its bytes one per transaction.
module usan_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  usan_pkg::head_t head,
    output logic            head_pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            stream_done
);

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       run_last_reg;
    logic       stream_done_reg;
    logic [1:0] idx_reg;
    logic       load;
    logic       last;

    assign load     = head.valid && (!out_valid_reg || !out_stall);
    assign last     = (({1'b0, idx_reg} + 3'd1) == head.run.count);
    assign head_pop = load && last;

    // Byte index within the current run.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else if (load)
        begin
            idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg    <= head.run.bytes[idx_reg];
            run_last_reg    <= last;
            stream_done_reg <= last && head.run.done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign run_last    = run_last_reg;
    assign stream_done = stream_done_reg;

endmodule

### rtl/utf8_stream_sanitizer.sv
// Top level of the UTF-8 stream sanitizer.
// The block takes one byte per cycle while the queue is not full and emits one
// byte per cycle while the output is not stalled. ASCII bytes 20h to 7Fh, tab,
// newline and complete 2-, 3- and 4-byte UTF-8 sequences with leads C0h to F7h
// pass through; every other byte comes out as '?'. A byte that completes or
// breaks a sequence causes a run of up to four output bytes, which leaves the
// output one byte per transaction; an input byte that is only held causes none.
// Runs wait in a queue of QUEUE_DEPTH entries, and the input stalls only when
// that queue is full, so the sustained rate is one input byte per cycle whenever
// the output is not stalled and runs average one byte. An accepted byte's run is
// written into the queue, and its bytes then pass through the output register of
// the back part. run_last marks the last result of each input byte, and
// stream_done the last result of a final byte.
module utf8_stream_sanitizer
#(
    parameter int QUEUE_DEPTH = usan_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       stream_done
);

    logic            run_write;
    usan_pkg::run_t  run_data;
    logic            queue_full;
    logic            head_pop;
    usan_pkg::head_t head;

    // Classification and sequence tracking.
    usan_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .final_byte (final_byte),
        .queue_full (queue_full),
        .run_write  (run_write),
        .run_data   (run_data)
    );

    // Run queue decoupling the two sides.
    usan_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (run_write),
        .wr_data (run_data),
        .full    (queue_full),
        .rd_en   (head_pop),
        .head    (head)
    );

    // Serialization onto the output channel.
    usan_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_pop    (head_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .stream_done (stream_done)
    );

endmodule

### tb/tb_utf8_stream_sanitizer.sv
// Self-checking testbench for the UTF-8 stream sanitizer.
`timescale 1ns / 1ps

module tb_utf8_stream_sanitizer;

    // Number of input bytes after which the random stimulus stops.
    localparam int ITEMS_TOTAL = 310;
    // Length of the single long output stall.
    localparam int LONG_HOLD = 40;
    // Cycles to wait after the last expected byte has arrived.
    localparam int DRAIN_CYCLES = 8;
    // Number of mismatches printed in full.
    localparam int REPORT_LIMIT = 10;

    // Kinds of stimulus units that make up a random stream.
    typedef enum int
    {
        KIND_TEXT,
        KIND_CTRL,
        KIND_SEQ,
        KIND_BROKEN,
        KIND_STRAY,
        KIND_BAD_LEAD
    } unit_kind_t;

    // One output byte together with its flags.
    typedef struct packed
    {
        logic [7:0] ob;
        logic       rl;
        logic       sd;
    } san_out_t;

    // One row of the directed table; typed rows carry a single known result.
    typedef struct packed
    {
        logic [7:0] b;
        logic       fin;
        logic       typed;
        logic [7:0] want;
    } dir_row_t;

    localparam int DIR_ROWS = 27;
    localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
        '{8'h00, 1'b0, 1'b1, 8'h3F},   // NUL is replaced
        '{8'h09, 1'b0, 1'b1, 8'h09},   // tab passes
        '{8'h0A, 1'b0, 1'b1, 8'h0A},   // newline passes
        '{8'h0D, 1'b0, 1'b1, 8'h3F},   // carriage return is replaced
        '{8'h1F, 1'b0, 1'b1, 8'h3F},   // highest control byte
        '{8'h20, 1'b0, 1'b1, 8'h20},   // lowest printable byte
        '{8'h7F, 1'b0, 1'b1, 8'h7F},   // highest ASCII byte passes
        '{8'h80, 1'b0, 1'b1, 8'h3F},   // stray continuation, low end
        '{8'hBF, 1'b0, 1'b1, 8'h3F},   // stray continuation, high end
        '{8'hF8, 1'b0, 1'b1, 8'h3F},   // invalid lead, low end
        '{8'hFF, 1'b0, 1'b1, 8'h3F},   // invalid lead, high end
        '{8'hC0, 1'b0, 1'b0, 8'h00},   // two-byte sequence
        '{8'h80, 1'b0, 1'b0, 8'h00},
        '{8'hE0, 1'b0, 1'b0, 8'h00},   // three-byte sequence
        '{8'hBF, 1'b0, 1'b0, 8'h00},
        '{8'h80, 1'b0, 1'b0, 8'h00},
        '{8'hF7, 1'b0, 1'b0, 8'h00},   // four-byte sequence, highest lead
        '{8'h80, 1'b0, 1'b0, 8'h00},
        '{8'h81, 1'b0, 1'b0, 8'h00},
        '{8'hBF, 1'b0, 1'b0, 8'h00},
        '{8'hF0, 1'b0, 1'b0, 8'h00},   // broken by a new lead
        '{8'h90, 1'b0, 1'b0, 8'h00},
        '{8'hC3, 1'b0, 1'b0, 8'h00},
        '{8'hA9, 1'b0, 1'b0, 8'h00},
        '{8'hE5, 1'b0, 1'b0, 8'h00},   // cut off by the final byte
        '{8'h88, 1'b1, 1'b0, 8'h00},
        '{8'hDF, 1'b1, 1'b1, 8'h3F}    // lead on the final byte
    };

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       final_byte = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;

    // Shadow of the sequence tracker.
    logic [7:0] seq_lead;
    logic [1:0] seq_need;
    logic [7:0] seq_held [2];
    logic [1:0] seq_nheld;

    logic [7:0] run_bytes [$];
    san_out_t   expected_out [$];
    logic [7:0] stream_q [$];

    bit       no_idle = 1'b0;
    bit       long_hold_req = 1'b0;
    int       fail_count = 0;
    int       n_items = 0;
    int       n_checked = 0;
    int       n_streams = 0;
    int       n_complete = 0;
    int       n_replaced = 0;
    san_out_t got;
    san_out_t want;

    utf8_stream_sanitizer dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .final_byte  (final_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .stream_done (stream_done)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Add one byte to the end of the current run.
    function automatic void run_add(input logic [7:0] v);
        run_bytes.insert(run_bytes.size(), v);
    endfunction

    // Add one byte to the end of the stream being built.
    function automatic void stream_add(input logic [7:0] v);
        stream_q.insert(stream_q.size(), v);
    endfunction

    // Drop any pending sequence.
    function automatic void clear_seq();
        seq_lead  = 8'h00;
        seq_need  = 2'd0;
        seq_nheld = 2'd0;
    endfunction

    // Replace the pending lead and every held byte.
    function automatic void flush_seq();
        run_add(usan_pkg::REPL_BYTE);
        for (int i = 0; i < int'(seq_nheld); i++)
            run_add(usan_pkg::REPL_BYTE);
        clear_seq();
    endfunction

    // Handle a byte as if no sequence were pending.
    function automatic void take_fresh(input logic [7:0] b, input logic fin);
        if (b < 8'h80)
            run_add((b >= 8'd32 || b == 8'h09 || b == 8'h0A) ? b : usan_pkg::REPL_BYTE);
        else if (b < 8'hC0 || b >= 8'hF8 || fin)
            run_add(usan_pkg::REPL_BYTE);
        else
        begin
            seq_lead  = b;
            seq_need  = (b < 8'hE0) ? 2'd1 : ((b < 8'hF0) ? 2'd2 : 2'd3);
            seq_nheld = 2'd0;
        end
    endfunction

    // Work out the output bytes caused by one input byte into run_bytes.
    function automatic void sanitize_byte(input logic [7:0] b, input logic fin);
        run_bytes.delete();
        if (seq_need != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                if (int'(seq_nheld) + 1 >= int'(seq_need))
                begin
                    run_add(seq_lead);
                    for (int i = 0; i < int'(seq_nheld); i++)
                        run_add(seq_held[i]);
                    run_add(b);
                    n_complete++;
                    clear_seq();
                end
                else if (fin)
                begin
                    flush_seq();
                    run_add(usan_pkg::REPL_BYTE);
                end
                else
                begin
                    seq_held[seq_nheld[0]] = b;
                    seq_nheld = seq_nheld + 2'd1;
                end
            end
            else
            begin
                flush_seq();
                take_fresh(b, fin);
            end
        end
        else
            take_fresh(b, fin);
        if (fin)
            clear_seq();
    endfunction

    // Offer one byte, wait until it is taken, then record what it must cause.
    task automatic apply_byte(input logic [7:0] b, input logic fin,
                              input logic typed, input logic [7:0] typed_byte);
        int       gap;
        san_out_t r;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_byte    <= b;
        final_byte <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n_items++;
        if (fin)
            n_streams++;
        sanitize_byte(b, fin);
        if (typed)
        begin
            run_bytes.delete();
            run_add(typed_byte);
        end
        for (int j = 0; j < run_bytes.size(); j++)
        begin
            r.ob = run_bytes[j];
            r.rl = (j == run_bytes.size() - 1);
            r.sd = r.rl && fin;
            if (r.ob == usan_pkg::REPL_BYTE)
                n_replaced++;
            expected_out.insert(expected_out.size(), r);
        end
    endtask

    function automatic logic [7:0] lead_for(input int len);
        if (len == 2)
            return 8'($urandom_range(8'hC0, 8'hDF));
        else if (len == 3)
            return 8'($urandom_range(8'hE0, 8'hEF));
        return 8'($urandom_range(8'hF0, 8'hF7));
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Build one random stream, nearly half of its units well-formed sequences, into stream_q.
    task automatic build_stream();
        int         roll;
        int         len;
        int         n_units;
        unit_kind_t kind;
        logic [7:0] b;
        stream_q.delete();
        n_units = $urandom_range(1, 8);
        repeat (n_units)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
                kind = KIND_SEQ;
            else if (roll < 65)
                kind = KIND_TEXT;
            else if (roll < 72)
                kind = KIND_CTRL;
            else if (roll < 82)
                kind = KIND_BROKEN;
            else if (roll < 90)
                kind = KIND_STRAY;
            else
                kind = KIND_BAD_LEAD;
            len = $urandom_range(2, 4);
            case (kind)
                KIND_TEXT:
                    stream_add(8'($urandom_range(32, 127)));
                KIND_CTRL:
                    stream_add(8'($urandom_range(0, 31)));
                KIND_SEQ:
                begin
                    stream_add(lead_for(len));
                    repeat (len - 1) stream_add(cont_byte());
                end
                KIND_BROKEN:
                begin
                    stream_add(lead_for(len));
                    repeat ($urandom_range(0, len - 2)) stream_add(cont_byte());
                    // Any byte that is not a continuation breaks the sequence.
                    b = 8'($urandom_range(0, 191));
                    if (b >= 8'h80)
                        b = b + 8'h40;
                    stream_add(b);
                end
                KIND_STRAY:
                    stream_add(cont_byte());
                default:
                    stream_add(8'($urandom_range(8'hF8, 8'hFF)));
            endcase
        end
        // Sometimes the stream ends inside a sequence.
        if ($urandom_range(0, 4) == 0)
        begin
            len = $urandom_range(2, 4);
            stream_add(lead_for(len));
            repeat ($urandom_range(0, len - 2)) stream_add(cont_byte());
        end
    endtask

    // Output side: random stalls per transaction plus one long hold.
    initial
    begin : receiver
        int wait_n;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            wait_n = no_idle ? 0 : $urandom_range(0, 5);
            if (wait_n > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Compare each output transaction with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            n_checked++;
            got = '{out_byte, run_last, stream_done};
            if (expected_out.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected output byte %02h last %0b done %0b",
                             got.ob, got.rl, got.sd);
            end
            else
            begin
                want = expected_out.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("mismatch: expected byte %02h last %0b done %0b,",
                                 want.ob, want.rl, want.sd,
                                 " got byte %02h last %0b done %0b",
                                 got.ob, got.rl, got.sd);
                end
            end
        end
    end

    // Stimulus: reset, directed table, random streams, drain.
    initial
    begin : stimulus
        bit pressure_done;
        pressure_done = 1'b0;
        clear_seq();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table; typed rows start from an idle tracker.
        for (int i = 0; i < DIR_ROWS; i++)
            apply_byte(DIRECTED[i].b, DIRECTED[i].fin, DIRECTED[i].typed, DIRECTED[i].want);

        // Random streams, each closed by a final byte.
        while (n_items < ITEMS_TOTAL)
        begin
            if (!pressure_done && n_items >= ITEMS_TOTAL / 2)
            begin
                // Hold the output off while text keeps arriving back to back.
                pressure_done = 1'b1;
                no_idle = 1'b1;
                long_hold_req = 1'b1;
                for (int i = 0; i < 30; i++)
                    apply_byte(8'($urandom_range(32, 127)), i == 29, 1'b0, 8'h00);
            end
            no_idle = ($urandom_range(0, 3) == 0);
            build_stream();
            for (int k = 0; k < stream_q.size(); k++)
                apply_byte(stream_q[k], k == stream_q.size() - 1, 1'b0, 8'h00);
        end
        in_valid <= 1'b0;
        no_idle = 1'b0;

        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d streams; checked %0d output bytes.",
                 n_items, n_streams, n_checked);
        $display("Seen %0d completed multi-byte sequences and %0d replaced bytes.",
                 n_complete, n_replaced);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
